### design/i2c_master_byte_engine_core_assert.svh
// Assertion macros for the checker file of the I2C master byte engine
`ifndef I2C_MASTER_BYTE_ENGINE_CORE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define I2CM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/i2cm_pkg.sv
// Types and constants shared by the I2C master byte engine modules
`default_nettype none

package i2cm_pkg;

    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_STOP  = 3'd2;
    localparam logic [2:0] MODE_WRITE = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd5;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] data_byte;
        logic       send_nack;
        logic       sda_level;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_drive;
        logic       sda_output_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_received;
    } result_t;

endpackage

`default_nettype wire

### design/i2c_master_byte_engine_core.sv
// Top level of the I2C master byte engine: input register, engine, result register
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  in      | into core | in_valid / in_stall  | mode, data_byte, send_nack, sda_level
//  out     | from core | out_valid / out_stall| scl_level, sda_drive, sda_output_enable,
//          |           |                      | busy_res, done_res, read_byte, ack_received
//  cfg     | into core | cfg_valid / cfg_ready| half_period_ticks
//
// One item per cycle while the output is not stalled; the input register takes an item at
// its accepting edge and the result register captures the result as the item advances.
// The engine state steps once per item. Reset returns the bus lines to high, the engine to
// idle, the half period to 5. A stalled result holds both registers; in_stall rises only
// while out_stall is high and the input register is full.
`default_nettype none

module i2c_master_byte_engine_core
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [2:0] mode,
    input  wire logic [7:0] data_byte,
    input  wire logic       send_nack,
    input  wire logic       sda_level,

    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            scl_level,
    output logic            sda_drive,
    output logic            sda_output_enable,
    output logic            busy_res,
    output logic            done_res,
    output logic [7:0]      read_byte,
    output logic            ack_received,

    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] half_period_ticks
);

    logic               in_valid_reg;
    i2cm_pkg::item_t    item_reg;
    logic               out_valid_reg;
    i2cm_pkg::result_t  result_reg;
    i2cm_pkg::result_t  result_next;
    logic [7:0]         half_period_reg;
    logic               advance;

    assign advance   = in_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall  = in_valid_reg && out_valid_reg && out_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= i2cm_pkg::HALF_PERIOD_RESET;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                half_period_reg <= half_period_ticks;
            end
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.mode      <= mode;
            item_reg.data_byte <= data_byte;
            item_reg.send_nack <= send_nack;
            item_reg.sda_level <= sda_level;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    i2cm_engine u_engine
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .item        (item_reg),
        .half_period (half_period_reg),
        .result      (result_next)
    );

    assign out_valid         = out_valid_reg;
    assign scl_level         = result_reg.scl_level;
    assign sda_drive         = result_reg.sda_drive;
    assign sda_output_enable = result_reg.sda_output_enable;
    assign busy_res          = result_reg.busy_res;
    assign done_res          = result_reg.done_res;
    assign read_byte         = result_reg.read_byte;
    assign ack_received      = result_reg.ack_received;

endmodule

`default_nettype wire

### design/i2cm_engine.sv
// Waveform state machine: state registers and the next-state logic for one item
`default_nettype none

module i2cm_engine
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire i2cm_pkg::item_t item,
    input  wire logic [7:0]      half_period,
    output i2cm_pkg::result_t    result
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START,
        PH_STOP,
        PH_WR_LO,
        PH_WR_HI,
        PH_WACK_LO,
        PH_WACK_HI,
        PH_WACK_END,
        PH_RD_LO,
        PH_RD_HI,
        PH_MACK_LO,
        PH_MACK_HI,
        PH_MACK_END
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [2:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] tick_reg, tick_next;
    logic       nack_reg, nack_next;
    logic       ack_reg, ack_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       oe_reg, oe_next;
    logic [7:0] last_read_reg, last_read_next;

    logic       enter_en;
    phase_t     enter_ph;
    logic [2:0] enter_sub;
    logic       done;
    logic [7:0] hp;
    logic [3:0] bit_inc;

    assign hp      = (half_period == 8'd0) ? 8'd1 : half_period;
    assign bit_inc = {1'b0, bit_reg} + 4'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        bit_next       = bit_reg;
        shift_next     = shift_reg;
        tick_next      = tick_reg;
        nack_next      = nack_reg;
        ack_next       = ack_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        oe_next        = oe_reg;
        last_read_next = last_read_reg;
        enter_en       = 1'b0;
        enter_ph       = PH_IDLE;
        enter_sub      = 3'd0;
        done           = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            case (item.mode)
                i2cm_pkg::MODE_START:
                begin
                    enter_en = 1'b1;
                    enter_ph = PH_START;
                end
                i2cm_pkg::MODE_STOP:
                begin
                    enter_en = 1'b1;
                    enter_ph = PH_STOP;
                end
                i2cm_pkg::MODE_WRITE:
                begin
                    shift_next = item.data_byte;
                    enter_en   = 1'b1;
                    enter_ph   = PH_WR_LO;
                end
                i2cm_pkg::MODE_READ:
                begin
                    shift_next = 8'd0;
                    nack_next  = item.send_nack;
                    enter_en   = 1'b1;
                    enter_ph   = PH_RD_LO;
                end
                default:
                begin
                end
            endcase
        end
        else if (item.mode == i2cm_pkg::MODE_TICK)
        begin
            if ({1'b0, tick_reg} + 9'd1 >= {1'b0, hp})
            begin
                // end of the current step
                enter_en = 1'b1;
                case (phase_reg)
                    PH_START, PH_STOP:
                    begin
                        if (bit_reg < 3'd3)
                        begin
                            enter_ph  = phase_reg;
                            enter_sub = bit_inc[2:0];
                        end
                        else
                        begin
                            enter_en = 1'b0;
                        end
                    end
                    PH_WR_LO:
                    begin
                        enter_ph  = PH_WR_HI;
                        enter_sub = bit_reg;
                    end
                    PH_WR_HI:
                    begin
                        shift_next = {shift_reg[6:0], 1'b0};
                        if (bit_inc[3])
                        begin
                            enter_ph = PH_WACK_LO;
                        end
                        else
                        begin
                            enter_ph  = PH_WR_LO;
                            enter_sub = bit_inc[2:0];
                        end
                    end
                    PH_WACK_LO: enter_ph = PH_WACK_HI;
                    PH_WACK_HI:
                    begin
                        ack_next = item.sda_level;
                        enter_ph = PH_WACK_END;
                    end
                    PH_RD_LO:
                    begin
                        enter_ph  = PH_RD_HI;
                        enter_sub = bit_reg;
                    end
                    PH_RD_HI:
                    begin
                        shift_next = {shift_reg[6:0], item.sda_level};
                        if (bit_inc[3])
                        begin
                            last_read_next = shift_next;
                            enter_ph       = PH_MACK_LO;
                        end
                        else
                        begin
                            enter_ph  = PH_RD_LO;
                            enter_sub = bit_inc[2:0];
                        end
                    end
                    PH_MACK_LO: enter_ph = PH_MACK_HI;
                    PH_MACK_HI: enter_ph = PH_MACK_END;
                    default:    enter_en = 1'b0;
                endcase

                if (!enter_en)
                begin
                    phase_next = PH_IDLE;
                    bit_next   = 3'd0;
                    tick_next  = 8'd0;
                    done       = 1'b1;
                end
            end
            else
            begin
                tick_next = tick_reg + 8'd1;
            end
        end

        if (enter_en)
        begin
            phase_next = enter_ph;
            bit_next   = enter_sub;
            tick_next  = 8'd0;
            case (enter_ph)
                PH_START:
                begin
                    oe_next  = 1'b1;
                    scl_next = (enter_sub == 3'd1) || (enter_sub == 3'd2);
                    sda_next = (enter_sub == 3'd0) || (enter_sub == 3'd1);
                end
                PH_STOP:
                begin
                    oe_next  = 1'b1;
                    scl_next = (enter_sub == 3'd2) || (enter_sub == 3'd3);
                    if (enter_sub != 3'd0)
                    begin
                        sda_next = (enter_sub == 3'd3);
                    end
                end
                PH_WR_LO:
                begin
                    scl_next = 1'b0;
                    sda_next = shift_next[7];
                    oe_next  = 1'b1;
                end
                PH_WACK_LO, PH_RD_LO:
                begin
                    scl_next = 1'b0;
                    oe_next  = 1'b0;
                end
                PH_MACK_LO:
                begin
                    scl_next = 1'b0;
                    sda_next = nack_next;
                    oe_next  = 1'b1;
                end
                PH_WR_HI, PH_WACK_HI, PH_RD_HI, PH_MACK_HI: scl_next = 1'b1;
                PH_WACK_END, PH_MACK_END:                   scl_next = 1'b0;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        result.scl_level         = scl_next;
        result.sda_drive         = sda_next;
        result.sda_output_enable = oe_next;
        result.busy_res          = (phase_next != PH_IDLE);
        result.done_res          = done;
        result.read_byte         = last_read_next;
        result.ack_received      = ack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_reg       <= 3'd0;
            shift_reg     <= 8'd0;
            tick_reg      <= 8'd0;
            nack_reg      <= 1'b0;
            ack_reg       <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            oe_reg        <= 1'b1;
            last_read_reg <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            bit_reg       <= bit_next;
            shift_reg     <= shift_next;
            tick_reg      <= tick_next;
            nack_reg      <= nack_next;
            ack_reg       <= ack_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            oe_reg        <= oe_next;
            last_read_reg <= last_read_next;
        end
    end

endmodule

`default_nettype wire

### design/i2cm_checker.sv
// Port-level checks for the I2C master byte engine, bound to the top level
`default_nettype none

`include "i2c_master_byte_engine_core_assert.svh"

module i2cm_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       busy_res,
    input wire logic       done_res,
    input wire logic       scl_level,
    input wire logic [7:0] read_byte
);

    // a completing item always leaves the engine idle
    `I2CM_ASSERT_NOW(a_done_idle, out_valid && done_res, !busy_res, "done with busy set")

    // back-pressure only passes upstream while the output is held
    `I2CM_ASSERT_NOW(a_stall_source, in_stall, out_stall, "input stalled without output stall")

    // a held result keeps its payload
    `I2CM_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(scl_level) && $stable(read_byte), "stalled item changed")

endmodule

bind i2c_master_byte_engine_core i2cm_checker u_i2cm_checker (.*);

`default_nettype wire

### bench/i2c_master_byte_engine_core_tb.sv
// Self-checking bench for the I2C master byte engine: random bus traffic against a line-level predictor
module i2c_master_byte_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam int LONG_HOLD     = 80;
    localparam int HOLD_SPACING  = 700;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RUN_LIMIT_NS  = 5_000_000;
    localparam int PLAN_LEN      = 6;

    typedef enum logic [3:0] {
        ST_IDLE, ST_START, ST_STOP,
        ST_WR_LO, ST_WR_HI, ST_WACK_LO, ST_WACK_HI, ST_WACK_END,
        ST_RD_LO, ST_RD_HI, ST_MACK_LO, ST_MACK_HI, ST_MACK_END
    } bus_step_e;

    typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_TOGGLE} flow_e;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [2:0] mode = MODE_TICK;
    logic [7:0] data_byte = 8'h00;
    logic       send_nack = 1'b0;
    logic       sda_level = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       scl_level;
    logic       sda_drive;
    logic       sda_output_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_received;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] half_period_ticks = HALF_PERIOD_RESET;

    i2c_master_byte_engine_core dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .mode              (mode),
        .data_byte         (data_byte),
        .send_nack         (send_nack),
        .sda_level         (sda_level),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .scl_level         (scl_level),
        .sda_drive         (sda_drive),
        .sda_output_enable (sda_output_enable),
        .busy_res          (busy_res),
        .done_res          (done_res),
        .read_byte         (read_byte),
        .ack_received      (ack_received),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .half_period_ticks (half_period_ticks)
    );

    item_t   bus_items[$];
    result_t line_state_due[$];

    logic       item_taken = 1'b0;
    int         phase_queued = 0;
    int         items_accepted = 0;
    int         results_seen = 0;
    int         ops_completed = 0;
    int         mismatches = 0;
    int         settings_used = 1;

    logic [7:0] hp_plan [PLAN_LEN] = '{8'd0, 8'd1, 8'd255, 8'd2, 8'd3, 8'd4};
    int         budget_plan [PLAN_LEN] = '{200, 400, 300, 300, 250, 200};

    // predictor copy of the engine
    logic [7:0] half_period_cfg;
    bus_step_e  bus_phase;
    logic [3:0] bus_idx;
    logic [7:0] bus_shift;
    logic [7:0] bus_ticks;
    logic       bus_nack;
    logic       bus_ack;
    logic       bus_scl;
    logic       bus_sda;
    logic       bus_oe;
    logic [7:0] bus_last_read;

    function void reset_line_model();
        half_period_cfg = HALF_PERIOD_RESET;
        bus_phase       = ST_IDLE;
        bus_idx         = '0;
        bus_shift       = '0;
        bus_ticks       = '0;
        bus_nack        = 1'b0;
        bus_ack         = 1'b0;
        bus_scl         = 1'b1;
        bus_sda         = 1'b1;
        bus_oe          = 1'b1;
        bus_last_read   = '0;
    endfunction

    function void enter_step(bus_step_e ph, logic [3:0] sub);
        bus_phase = ph;
        bus_idx   = sub;
        bus_ticks = '0;
        case (ph)
            ST_START:
            begin
                bus_oe = 1'b1;
                case (sub)
                    4'd0:    begin bus_scl = 1'b0; bus_sda = 1'b1; end
                    4'd1:    begin bus_scl = 1'b1; bus_sda = 1'b1; end
                    4'd2:    begin bus_scl = 1'b1; bus_sda = 1'b0; end
                    default: begin bus_scl = 1'b0; bus_sda = 1'b0; end
                endcase
            end
            ST_STOP:
            begin
                bus_oe = 1'b1;
                case (sub)
                    4'd0:    bus_scl = 1'b0;
                    4'd1:    begin bus_scl = 1'b0; bus_sda = 1'b0; end
                    4'd2:    begin bus_scl = 1'b1; bus_sda = 1'b0; end
                    default: begin bus_scl = 1'b1; bus_sda = 1'b1; end
                endcase
            end
            ST_WR_LO:
            begin
                bus_scl = 1'b0;
                bus_sda = bus_shift[7];
                bus_oe  = 1'b1;
            end
            ST_WACK_LO, ST_RD_LO:
            begin
                bus_scl = 1'b0;
                bus_oe  = 1'b0;
            end
            ST_MACK_LO:
            begin
                bus_scl = 1'b0;
                bus_sda = bus_nack;
                bus_oe  = 1'b1;
            end
            ST_WR_HI, ST_WACK_HI, ST_RD_HI, ST_MACK_HI:
                bus_scl = 1'b1;
            ST_WACK_END, ST_MACK_END:
                bus_scl = 1'b0;
            default: ;
        endcase
    endfunction

    // closes the current half period; 1 when the command is over
    function logic close_step(logic sda_in);
        case (bus_phase)
            ST_START, ST_STOP:
                if (bus_idx < 4'd3)
                begin
                    enter_step(bus_phase, bus_idx + 4'd1);
                    return 1'b0;
                end
            ST_WR_LO:
            begin
                enter_step(ST_WR_HI, bus_idx);
                return 1'b0;
            end
            ST_WR_HI:
            begin
                bus_shift = {bus_shift[6:0], 1'b0};
                if (bus_idx + 4'd1 >= 4'd8)
                    enter_step(ST_WACK_LO, 4'd0);
                else
                    enter_step(ST_WR_LO, bus_idx + 4'd1);
                return 1'b0;
            end
            ST_WACK_LO:
            begin
                enter_step(ST_WACK_HI, 4'd0);
                return 1'b0;
            end
            ST_WACK_HI:
            begin
                bus_ack = sda_in;
                enter_step(ST_WACK_END, 4'd0);
                return 1'b0;
            end
            ST_RD_LO:
            begin
                enter_step(ST_RD_HI, bus_idx);
                return 1'b0;
            end
            ST_RD_HI:
            begin
                bus_shift = {bus_shift[6:0], sda_in};
                if (bus_idx + 4'd1 >= 4'd8)
                begin
                    bus_last_read = bus_shift;
                    enter_step(ST_MACK_LO, 4'd0);
                end
                else
                    enter_step(ST_RD_LO, bus_idx + 4'd1);
                return 1'b0;
            end
            ST_MACK_LO:
            begin
                enter_step(ST_MACK_HI, 4'd0);
                return 1'b0;
            end
            ST_MACK_HI:
            begin
                enter_step(ST_MACK_END, 4'd0);
                return 1'b0;
            end
            default: ;
        endcase
        bus_phase = ST_IDLE;
        bus_idx   = '0;
        bus_ticks = '0;
        return 1'b1;
    endfunction

    function result_t next_line_state(item_t it);
        logic [7:0] hp;
        logic       finished;
        result_t    r;
        hp       = (half_period_cfg == 8'd0) ? 8'd1 : half_period_cfg;
        finished = 1'b0;
        if (bus_phase == ST_IDLE)
        begin
            case (it.mode)
                MODE_START: enter_step(ST_START, 4'd0);
                MODE_STOP:  enter_step(ST_STOP, 4'd0);
                MODE_WRITE:
                begin
                    bus_shift = it.data_byte;
                    enter_step(ST_WR_LO, 4'd0);
                end
                MODE_READ:
                begin
                    bus_shift = '0;
                    bus_nack  = it.send_nack;
                    enter_step(ST_RD_LO, 4'd0);
                end
                default: ;
            endcase
        end
        else if (it.mode == MODE_TICK)
        begin
            if ({1'b0, bus_ticks} + 9'd1 >= {1'b0, hp})
                finished = close_step(it.sda_level);
            else
                bus_ticks = bus_ticks + 8'd1;
        end
        r.scl_level         = bus_scl;
        r.sda_drive         = bus_sda;
        r.sda_output_enable = bus_oe;
        r.busy_res          = (bus_phase != ST_IDLE);
        r.done_res          = finished;
        r.read_byte         = bus_last_read;
        r.ack_received      = bus_ack;
        return r;
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t %s mismatch: expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic queue_item(input logic [2:0] m, input logic [7:0] d, input logic nk,
                              input logic s);
        item_t it;
        it.mode      = m;
        it.data_byte = d;
        it.send_nack = nk;
        it.sda_level = s;
        bus_items.push_back(it);
        phase_queued++;
    endtask

    task automatic queue_random_item(input logic [2:0] m);
        queue_item(m, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
    endtask

    // mostly complete commands with their full run of ticks, some noise and cut-short runs
    task automatic queue_traffic(input logic [7:0] hp_set, input int budget);
        int         hp_eff;
        int         ticks;
        int         target;
        logic [2:0] op;
        hp_eff = (hp_set == 8'd0) ? 1 : int'(hp_set);
        target = phase_queued + budget;
        while (phase_queued < target)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    queue_random_item(3'($urandom_range(0, 7)));
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       op = MODE_START;
                    1:       op = MODE_STOP;
                    2:       op = MODE_WRITE;
                    default: op = MODE_READ;
                endcase
                ticks = ((op == MODE_START || op == MODE_STOP) ? 4 : 19) * hp_eff;
                if ($urandom_range(0, 7) == 0)
                    ticks = $urandom_range(0, ticks);
                queue_random_item(op);
                while (ticks > 0 && phase_queued < target)
                begin
                    if ($urandom_range(0, 49) == 0)
                        queue_random_item(3'($urandom_range(1, 7)));
                    else
                    begin
                        queue_random_item(MODE_TICK);
                        ticks--;
                    end
                end
                repeat ($urandom_range(0, 2))
                    queue_random_item(MODE_TICK);
            end
        end
    endtask

    task automatic wait_drained();
        while (bus_items.size() != 0 || line_state_due.size() != 0 || in_valid)
            @(posedge clk);
    endtask

    task automatic write_half_period(input logic [7:0] v);
        @(negedge clk);
        cfg_valid         <= 1'b1;
        half_period_ticks <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        half_period_cfg = v;
        settings_used++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("[i2c_master_byte_engine_core] ERROR");
        $finish;
    end

    // sender: bursts of items separated by random gaps
    always @(negedge clk)
    begin
        int gap_left;
        int burst_left;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            gap_left   = 0;
            burst_left = 0;
        end
        else if (!in_valid || item_taken)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (bus_items.size() == 0)
                in_valid <= 1'b0;
            else
            begin
                in_valid  <= 1'b1;
                mode      <= bus_items[0].mode;
                data_byte <= bus_items[0].data_byte;
                send_nack <= bus_items[0].send_nack;
                sda_level <= bus_items[0].sda_level;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 40);
                    if ($urandom_range(0, 2) == 0)
                        gap_left = 0;
                    else if ($urandom_range(0, 9) == 0)
                        gap_left = $urandom_range(10, 25);
                    else
                        gap_left = $urandom_range(1, 4);
                end
                else
                    burst_left--;
            end
        end
    end

    // receiver: changing stall pattern, plus long hold-offs spaced by result count
    always @(negedge clk)
    begin
        int    hold_left;
        int    next_hold_at;
        int    flow_left;
        flow_e flow;
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            hold_left    = 0;
            next_hold_at = 400;
            flow_left    = 0;
            flow         = FLOW_FREE;
        end
        else
        begin
            if (hold_left == 0 && results_seen >= next_hold_at)
            begin
                hold_left    = LONG_HOLD;
                next_hold_at = next_hold_at + HOLD_SPACING;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (flow_left == 0)
                begin
                    flow      = flow_e'($urandom_range(0, 3));
                    flow_left = $urandom_range(5, 60);
                end
                flow_left--;
                case (flow)
                    FLOW_FREE:  out_stall <= 1'b0;
                    FLOW_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    FLOW_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:    out_stall <= !out_stall;
                endcase
            end
        end
    end

    // monitor: predicts on each accepted item, checks each accepted result
    always @(posedge clk)
    begin
        result_t seen;
        result_t want;
        item_t   taken;
        item_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && out_valid && !out_stall)
        begin
            seen.scl_level         = scl_level;
            seen.sda_drive         = sda_drive;
            seen.sda_output_enable = sda_output_enable;
            seen.busy_res          = busy_res;
            seen.done_res          = done_res;
            seen.read_byte         = read_byte;
            seen.ack_received      = ack_received;
            results_seen++;
            if (line_state_due.size() == 0)
            begin
                $display("%0t unexpected result: expected none, got %0h", $time, seen);
                mismatches++;
            end
            else
            begin
                want = line_state_due.pop_front();
                check_field("scl_level", want.scl_level, seen.scl_level);
                check_field("sda_drive", want.sda_drive, seen.sda_drive);
                check_field("sda_output_enable", want.sda_output_enable,
                            seen.sda_output_enable);
                check_field("busy_res", want.busy_res, seen.busy_res);
                check_field("done_res", want.done_res, seen.done_res);
                check_field("read_byte", want.read_byte, seen.read_byte);
                check_field("ack_received", want.ack_received, seen.ack_received);
                if (want.done_res)
                    ops_completed++;
            end
        end
        if (rst_n && in_valid && !in_stall)
        begin
            taken.mode      = mode;
            taken.data_byte = data_byte;
            taken.send_nack = send_nack;
            taken.sda_level = sda_level;
            line_state_due.push_back(next_line_state(taken));
            void'(bus_items.pop_front());
            items_accepted++;
        end
    end

    initial
    begin
        reset_line_model();
        hp_plan[PLAN_LEN - 1] = 8'($urandom_range(4, 9));
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // idle tick, spare modes, then a start with commands landing while busy
        queue_item(MODE_TICK, 8'h00, 1'b0, 1'b0);
        queue_item(MODE_SPARE_LO, 8'hFF, 1'b1, 1'b1);
        queue_item(MODE_SPARE_HI, 8'hFF, 1'b1, 1'b1);
        queue_item(MODE_START, 8'h00, 1'b0, 1'b0);
        for (int i = 0; i < 20; i++)
        begin
            if (i == 3)
                queue_item(MODE_STOP, 8'h00, 1'b0, 1'b1);
            if (i == 8)
                queue_item(MODE_WRITE, 8'hFF, 1'b1, 1'b0);
            if (i == 13)
                queue_item(MODE_READ, 8'h5A, 1'b1, 1'b1);
            queue_item(MODE_TICK, 8'hFF, i[0], i[0]);
        end
        queue_traffic(HALF_PERIOD_RESET, 150);
        wait_drained();

        for (int p = 0; p < PLAN_LEN; p++)
        begin
            write_half_period(hp_plan[p]);
            queue_traffic(hp_plan[p], budget_plan[p]);
            wait_drained();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d items and %0d results through %0d half-period settings,",
                 items_accepted, results_seen, settings_used);
        $display("with %0d bus operations completed and %0d mismatches.",
                 ops_completed, mismatches);
        if (mismatches == 0)
            $display("[i2c_master_byte_engine_core] OK");
        else
            $display("[i2c_master_byte_engine_core] ERROR");
        $finish;
    end

endmodule
